FILE: src/ordered_list_with_key_delete_defines.svh
// Assertion helpers for the ordered list block.
`ifndef ORDERED_LIST_WITH_KEY_DELETE_DEFINES_SVH
`define ORDERED_LIST_WITH_KEY_DELETE_DEFINES_SVH

// Same-cycle implication.
`define OLKD_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olkd assertion failed");

// Next-cycle implication.
`define OLKD_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olkd assertion failed");

`endif

FILE: src/olkd_pkg.sv
package olkd_pkg;

	localparam int DATA_W = 32;

	// operation codes
	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_DEL_HEAD = 3'd1;
	localparam logic [2:0] OP_DEL_TAIL = 3'd2;
	localparam logic [2:0] OP_DEL_KEY  = 3'd3;
	localparam logic [2:0] OP_LIST     = 3'd4;

	// status codes
	localparam logic [2:0] STS_DONE     = 3'd0;
	localparam logic [2:0] STS_EMPTY    = 3'd1;
	localparam logic [2:0] STS_NOTFOUND = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_ITEM     = 3'd4;

	// controls shared by every cell of the chain
	typedef struct packed {
		logic cap;   // latch key compare, clear seen flag
		logic prop;  // move seen flag one cell toward the tail
		logic rot;   // every cell takes its right neighbor (ring)
		logic kdel;  // cells at or past the first match take right neighbor
	} cell_ctl_t;

endpackage

FILE: src/olkd_cell.sv
module olkd_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olkd_pkg::cell_ctl_t                 ctl,
	input  logic                                wr_en,
	input  logic                                live,
	input  logic signed [olkd_pkg::DATA_W-1:0]  din,
	input  logic signed [olkd_pkg::DATA_W-1:0]  right_data,
	input  logic                                left_seen,
	input  logic                                left_match,
	output logic signed [olkd_pkg::DATA_W-1:0]  data,
	output logic                                match,
	output logic                                seen
);
	import olkd_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic                     match_q;
	logic                     seen_q;

	// element storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q <= din;
		end else if (ctl.rot) begin
			data_q <= right_data;
		end else if (ctl.kdel && (seen_q || match_q)) begin
			data_q <= right_data;
		end
	end

	// key match and "match seen earlier" flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (ctl.cap) begin
			match_q <= live && (data_q == din);
			seen_q  <= 1'b0;
		end else if (ctl.prop) begin
			seen_q <= left_seen || left_match;
		end
	end

	assign data  = data_q;
	assign match = match_q;
	assign seen  = seen_q;

endmodule

FILE: src/ordered_list_with_key_delete.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------
// command   | start / busy       | operation[2:0], value[31:0]
// result    | valid (strobe)     | status[2:0], item[31:0], final_res
//
// Insert, delete-head and delete-tail: busy stays low, the status transfer
//   appears on the next cycle, and a new command may follow at once.
// Delete-key on a non-empty list: busy while walking the match flag down the
//   cell chain, then the close-up; result on the next cycle.
// List on a non-empty list: busy rotating the chain once round; one item
//   transfer per cycle while elements remain, so up to CAPACITY transfers.
// Reset clears the element count, flags and state; element data is not reset.
// The receiver cannot stall: every transfer is taken in the cycle it shows.
`include "ordered_list_with_key_delete_defines.svh"

module ordered_list_with_key_delete #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          operation,
	input  logic signed [olkd_pkg::DATA_W-1:0]  value,
	output logic                                valid,
	output logic [2:0]                          status,
	output logic signed [olkd_pkg::DATA_W-1:0]  item,
	output logic                                final_res
);
	import olkd_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);   // element count width
	localparam int IW = $clog2(CAPACITY);       // walk counter width
	localparam logic [IW-1:0] CNT_LAST = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(CAPACITY);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEY  = 2'd1;
	localparam logic [1:0] ST_LIST = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [CW-1:0] count_q;

	logic                     valid_q;
	logic [2:0]               status_q;
	logic signed [DATA_W-1:0] item_q;
	logic                     final_q;

	cell_ctl_t ctl;
	logic      acc;
	logic      empty;
	logic      found;

	logic signed [DATA_W-1:0] cell_data  [CAPACITY];
	logic [CAPACITY-1:0]      cell_match;
	logic [CAPACITY-1:0]      cell_seen;

	assign busy  = (state_q != ST_IDLE);
	assign acc   = start && !busy;
	assign empty = (count_q == '0);
	assign found = |cell_match;

	// Chain controls. Delete-head rotates the ring one place: the old head
	// lands past the tail, where the shrunken count no longer sees it.
	always_comb begin
		ctl.cap  = acc && (operation == OP_DEL_KEY) && !empty;
		ctl.prop = (state_q == ST_KEY) && (cnt_q != CNT_LAST);
		ctl.kdel = (state_q == ST_KEY) && (cnt_q == CNT_LAST) && found;
		ctl.rot  = (acc && (operation == OP_DEL_HEAD) && !empty) || (state_q == ST_LIST);
	end

	// Cell 0 is the head; cell i takes data from cell i+1, the last from cell 0.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic wr_en;
		logic live;
		logic lseen;
		logic lmatch;

		assign wr_en = acc && (operation == OP_INSERT) && (count_q == CW'(i));
		assign live  = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign lseen  = 1'b0;
			assign lmatch = 1'b0;
		end else begin : g_rest
			assign lseen  = cell_seen[i-1];
			assign lmatch = cell_match[i-1];
		end

		olkd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.wr_en      (wr_en),
			.live       (live),
			.din        (value),
			.right_data (cell_data[(i + 1) % CAPACITY]),
			.left_seen  (lseen),
			.left_match (lmatch),
			.data       (cell_data[i]),
			.match      (cell_match[i]),
			.seen       (cell_seen[i])
		);
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			count_q  <= '0;
			valid_q  <= 1'b0;
			status_q <= STS_DONE;
			item_q   <= '0;
			final_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (operation)
							OP_INSERT: begin
								valid_q  <= 1'b1;
								item_q   <= '0;
								final_q  <= 1'b1;
								if (count_q == COUNT_MAX) begin
									status_q <= STS_FULL;
								end else begin
									status_q <= STS_DONE;
									count_q  <= count_q + CW'(1);
								end
							end
							OP_DEL_HEAD, OP_DEL_TAIL: begin
								valid_q <= 1'b1;
								item_q  <= '0;
								final_q <= 1'b1;
								if (empty) begin
									status_q <= STS_EMPTY;
								end else begin
									status_q <= STS_DONE;
									count_q  <= count_q - CW'(1);
								end
							end
							OP_DEL_KEY, OP_LIST: begin
								if (empty) begin
									valid_q  <= 1'b1;
									status_q <= STS_EMPTY;
									item_q   <= '0;
									final_q  <= 1'b1;
								end else begin
									state_q <= (operation == OP_LIST) ? ST_LIST : ST_KEY;
									cnt_q   <= '0;
								end
							end
							default: begin
								// unused codes: no transfer, no change
							end
						endcase
					end
				end
				ST_KEY: begin
					if (cnt_q != CNT_LAST) begin
						cnt_q <= cnt_q + IW'(1);
					end else begin
						valid_q  <= 1'b1;
						item_q   <= '0;
						final_q  <= 1'b1;
						status_q <= found ? STS_DONE : STS_NOTFOUND;
						if (found) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LIST: begin
					// head of the rotating ring is the next element in order
					if (CW'(cnt_q) < count_q) begin
						valid_q  <= 1'b1;
						status_q <= STS_ITEM;
						item_q   <= cell_data[0];
						final_q  <= ((CW'(cnt_q) + CW'(1)) == count_q);
					end
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign valid     = valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign final_res = final_q;

	`OLKD_IMPLY(a_count_range, 1'b1, count_q <= COUNT_MAX)
	`OLKD_NEXT(a_insert_grows, acc && operation == OP_INSERT && count_q != COUNT_MAX, count_q == $past(count_q) + CW'(1))
	`OLKD_NEXT(a_key_result, state_q == ST_KEY && cnt_q == CNT_LAST, valid && final_res && (status == STS_DONE || status == STS_NOTFOUND))

endmodule
